// File: hdl/sed_pkg.sv
// Shared types, character constants and small decode functions for the
// string escape decoder. No dependencies.
`timescale 1ns / 1ps

package sed_pkg;

  // Characters that steer the decoder.
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote     = 8'h27;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChQuestion  = 8'h3F;
  localparam logic [7:0] ChLowA      = 8'h61;
  localparam logic [7:0] ChLowB      = 8'h62;
  localparam logic [7:0] ChLowF      = 8'h66;
  localparam logic [7:0] ChLowN      = 8'h6E;
  localparam logic [7:0] ChLowR      = 8'h72;
  localparam logic [7:0] ChLowT      = 8'h74;
  localparam logic [7:0] ChLowV      = 8'h76;
  localparam logic [7:0] ChLowX      = 8'h78;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChSeven     = 8'h37;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChUpA       = 8'h41;
  localparam logic [7:0] ChUpF       = 8'h46;

  // Control codes produced by the letter escapes.
  localparam logic [7:0] CodeBel = 8'd7;
  localparam logic [7:0] CodeBs  = 8'd8;
  localparam logic [7:0] CodeFf  = 8'd12;
  localparam logic [7:0] CodeLf  = 8'd10;
  localparam logic [7:0] CodeCr  = 8'd13;
  localparam logic [7:0] CodeTab = 8'd9;
  localparam logic [7:0] CodeVt  = 8'd11;

  localparam logic [7:0] CodeMaxReset = 8'd127;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_OCT   = 3'd2,
    MODE_HEX0  = 3'd3,
    MODE_HEX   = 3'd4
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] acc;
    logic       over;
    logic       failed;
  } sed_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       bad;
    logic       literal_done;
    logic       run_last;
  } sed_res_t;

  function automatic logic is_oct(input logic [7:0] b);
    return (b >= ChZero) && (b <= ChSeven);
  endfunction

  // Returns {valid, value} for a hex digit in either case.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if ((b >= ChZero) && (b <= ChNine)) begin
      r = {1'b1, b[3:0]};
    end else if (((b >= ChLowA) && (b <= ChLowF)) || ((b >= ChUpA) && (b <= ChUpF))) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Returns {valid, code} for the single-character escapes.
  function automatic logic [8:0] esc_code(input logic [7:0] b);
    logic [8:0] r;
    r = 9'd0;
    case (b)
      ChQuote, ChDquote, ChQuestion, ChBackslash: r = {1'b1, b};
      ChLowA:  r = {1'b1, CodeBel};
      ChLowB:  r = {1'b1, CodeBs};
      ChLowF:  r = {1'b1, CodeFf};
      ChLowN:  r = {1'b1, CodeLf};
      ChLowR:  r = {1'b1, CodeCr};
      ChLowT:  r = {1'b1, CodeTab};
      ChLowV:  r = {1'b1, CodeVt};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic sed_res_t mk_res(input logic [7:0] data, input logic has,
                                      input logic bad);
    sed_res_t r;
    r.data         = data;
    r.has_byte     = has;
    r.bad          = bad;
    r.literal_done = 1'b0;
    r.run_last     = 1'b0;
    return r;
  endfunction

endpackage

// File: hdl/sed_step.sv
// Next-state and result logic for one input byte of the escape decoder.
// Purely combinational; depends on sed_pkg.
`timescale 1ns / 1ps

module sed_step (
  input  sed_pkg::sed_state_t cur_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic [7:0]          code_max_i,
  output sed_pkg::sed_state_t nxt_o,
  output sed_pkg::sed_res_t   res0_o,
  output sed_pkg::sed_res_t   res1_o,
  output logic [1:0]          cnt_o
);
  import sed_pkg::*;

  sed_state_t s;
  sed_res_t   r [2];
  logic [1:0] n;
  logic       do_plain;
  logic       code_err;
  logic [4:0] hx;
  logic [8:0] ec;

  assign code_err = cur_i.over || (cur_i.acc > code_max_i);
  assign hx       = hex_digit(byte_i);
  assign ec       = esc_code(byte_i);

  always_comb begin
    s        = cur_i;
    n        = 2'd0;
    do_plain = 1'b0;
    r[0]     = mk_res(8'd0, 1'b0, 1'b0);
    r[1]     = mk_res(8'd0, 1'b0, 1'b0);

    if (!cur_i.failed) begin
      unique case (cur_i.mode)
        MODE_ESC: begin
          s.mode = MODE_PLAIN;
          if (ec[8]) begin
            r[n[0]] = mk_res(ec[7:0], 1'b1, 1'b0);
            n = n + 2'd1;
          end else if (is_oct(byte_i)) begin
            s.mode = MODE_OCT;
            s.acc  = {5'd0, byte_i[2:0]};
            s.over = 1'b0;
          end else if (byte_i == ChLowX) begin
            s.mode = MODE_HEX0;
            s.acc  = 8'd0;
            s.over = 1'b0;
          end
        end
        MODE_OCT, MODE_HEX: begin
          if ((cur_i.mode == MODE_OCT) && is_oct(byte_i)) begin
            s.acc  = {cur_i.acc[4:0], byte_i[2:0]};
            s.over = cur_i.over || (cur_i.acc[7:5] != 3'd0);
          end else if ((cur_i.mode == MODE_HEX) && hx[4]) begin
            s.acc  = {cur_i.acc[3:0], hx[3:0]};
            s.over = cur_i.over || (cur_i.acc[7:4] != 4'd0);
          end else begin
            // The run ends here; unless the code is out of range, the terminating byte is then handled as plain text.
            s.mode = MODE_PLAIN;
            if (code_err) begin
              r[n[0]]  = mk_res(8'd0, 1'b0, 1'b1);
              s.failed = 1'b1;
            end else begin
              r[n[0]]  = mk_res(cur_i.acc, 1'b1, 1'b0);
              do_plain = 1'b1;
            end
            n = n + 2'd1;
          end
        end
        MODE_HEX0: begin
          if (hx[4]) begin
            s.mode = MODE_HEX;
            s.acc  = {4'd0, hx[3:0]};
            s.over = 1'b0;
          end else begin
            r[n[0]]  = mk_res(8'd0, 1'b0, 1'b1);
            n        = n + 2'd1;
            s.failed = 1'b1;
            s.mode   = MODE_PLAIN;
          end
        end
        default: begin
          s.mode   = MODE_PLAIN;
          do_plain = 1'b1;
        end
      endcase

      if (do_plain) begin
        if (byte_i == ChBackslash) begin
          s.mode = MODE_ESC;
        end else begin
          r[n[0]] = mk_res(byte_i, 1'b1, 1'b0);
          n = n + 2'd1;
        end
      end

      // Close whatever is still open at the end of the literal.
      if (last_i && !s.failed) begin
        if ((s.mode == MODE_OCT) || (s.mode == MODE_HEX)) begin
          if (s.over || (s.acc > code_max_i)) begin
            r[n[0]] = mk_res(8'd0, 1'b0, 1'b1);
          end else begin
            r[n[0]] = mk_res(s.acc, 1'b1, 1'b0);
          end
          n = n + 2'd1;
        end else if ((s.mode == MODE_HEX0) || (s.mode == MODE_ESC)) begin
          r[n[0]] = mk_res(8'd0, 1'b0, 1'b1);
          n = n + 2'd1;
        end
      end
    end

    if (last_i) begin
      if (n == 2'd0) begin
        r[0] = mk_res(8'd0, 1'b0, 1'b0);
        n    = 2'd1;
      end
      s.mode   = MODE_PLAIN;
      s.acc    = 8'd0;
      s.over   = 1'b0;
      s.failed = 1'b0;
    end

    if (n == 2'd1) begin
      r[0].run_last     = 1'b1;
      r[0].literal_done = last_i;
    end else if (n == 2'd2) begin
      r[1].run_last     = 1'b1;
      r[1].literal_done = last_i;
    end
  end

  assign nxt_o  = s;
  assign res0_o = r[0];
  assign res1_o = r[1];
  assign cnt_o  = n;

endmodule

// File: hdl/string_escape_decoder.sv
// Top level of the string escape decoder: input register, step logic and
// result queue. Depends on sed_pkg and sed_step.
`timescale 1ns / 1ps

// Decodes the escapes of a string literal body arriving one byte per transaction.
// A byte is taken every cycle while the queue has room for two results; it is
// registered, decoded by one layer of logic and its zero, one or two results are
// pushed into a four-entry result queue, from which one result leaves per output
// transaction. A byte that yields two results (a numeric escape ended by a plain
// byte, or by a backslash at the last byte) needs two output transactions, so the
// queue's drain rate of one result per cycle while the output is ready sets the
// sustained rate whenever such bytes are frequent. code_max may be written while
// the block is idle.
module string_escape_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,     // code_max
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  input  logic       s_axis_tlast_i,  // in_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic [2:0] m_axis_tuser_o,  // [0] has_byte, [1] bad, [2] run_last
  output logic       m_axis_tlast_o   // literal_done
);
  import sed_pkg::*;

  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);
  localparam int CntW   = $clog2(QDepth + 1);

  logic [7:0]   code_max_q;
  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  sed_state_t   state_q, state_d;
  sed_res_t     res0, res1;
  logic [1:0]   res_cnt;
  sed_res_t     queue_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic         commit, in_fire, out_fire;

  sed_step u_step (
    .cur_i      (state_q),
    .byte_i     (in_byte_q),
    .last_i     (in_last_q),
    .code_max_i (code_max_q),
    .nxt_o      (state_d),
    .res0_o     (res0),
    .res1_o     (res1),
    .cnt_o      (res_cnt)
  );

  // Commit only when the queue can take two results, so the decision does not
  // depend on the output side's ready in the same cycle.
  assign commit          = in_valid_q && (count_q <= CntW'(QDepth - 2));
  assign s_axis_tready_o = !in_valid_q || commit;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (count_q != '0);
  assign out_fire        = m_axis_tvalid_o && m_axis_tready_i;

  assign m_axis_tdata_o = queue_q[rd_ptr_q].data;
  assign m_axis_tuser_o = {queue_q[rd_ptr_q].run_last, queue_q[rd_ptr_q].bad,
                           queue_q[rd_ptr_q].has_byte};
  assign m_axis_tlast_o = queue_q[rd_ptr_q].literal_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_max_q <= CodeMaxReset;
    end else if (cfg_we_i) begin
      code_max_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (commit) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode   <= MODE_PLAIN;
      state_q.acc    <= 8'd0;
      state_q.over   <= 1'b0;
      state_q.failed <= 1'b0;
    end else if (commit) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      if (res_cnt != 2'd0) begin
        queue_q[wr_ptr_q] <= res0;
      end
      if (res_cnt == 2'd2) begin
        queue_q[wr_ptr_q + PtrW'(1)] <= res1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (commit) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(res_cnt);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + (commit ? CntW'(res_cnt) : CntW'(0))
                         - (out_fire ? CntW'(1) : CntW'(0));
    end
  end

endmodule

// File: hdl/sed_checker.sv
// Port-level checks for the string escape decoder and the bind that attaches
// them to the top level. Depends on string_escape_decoder.
`timescale 1ns / 1ps

module sed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [2:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  // A pending result may not change or vanish before it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
       && $stable(m_axis_tlast_o)))
    else $error("result changed while stalled");

  // The end of a literal is always the last result of its byte.
  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> m_axis_tuser_o[2])
    else $error("literal end without run end");

  // An error result never carries a byte.
  a_bad_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> !m_axis_tuser_o[0])
    else $error("error result carries a byte");

  // Results without a byte carry zero data.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o == 8'd0))
    else $error("nonzero data without a byte");

  // An empty result that is not an error only marks the end of a literal.
  a_empty_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0] && !m_axis_tuser_o[1]) |-> m_axis_tlast_o)
    else $error("empty result outside literal end");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
